>>> sv/allocation_reuse_monitor_defines.svh
// assertion macros shared by the allocation reuse monitor rtl
`ifndef ALLOCATION_REUSE_MONITOR_DEFINES_SVH
`define ALLOCATION_REUSE_MONITOR_DEFINES_SVH

// condition that must hold at every clock edge out of reset
`define ARM_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that must hold in the same cycle as its antecedent
`define ARM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequence that must hold in the cycle after its antecedent
`define ARM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/arm_pkg.sv
// shared types, constants and helpers of the allocation reuse monitor
`default_nettype none
package arm_pkg;

    localparam int TB        = 12;
    localparam int SLOTS     = 1 << TB;
    localparam int MAX_TESTS = 256;
    localparam int MT_BITS   = $clog2(MAX_TESTS);
    localparam int EW        = 32;
    localparam int HIST      = 64;
    localparam int HB        = 6;
    localparam int NHIST     = 4;
    localparam int NTOT      = 14;
    localparam int NPT       = 6;
    localparam int GEN_LIMIT = 254;
    localparam int QDEPTH    = 2;
    localparam int CLR_BITS  = (TB > 8) ? TB : 8;
    localparam logic [63:0] HASH_MUL = 64'h9E3779B97F4A7C15;

    // totals index
    localparam int TOT_ALLOC    = 0;
    localparam int TOT_FREE     = 1;
    localparam int TOT_BYTES    = 2;
    localparam int TOT_REALLOC  = 3;
    localparam int TOT_LIVE     = 4;
    localparam int TOT_PEAK     = 5;
    localparam int TOT_MAXREUSE = 6;
    localparam int TOT_DISTINCT = 7;
    localparam int TOT_FBYTES   = 8;
    localparam int TOT_BEYOND   = 9;
    localparam int TOT_POISON   = 10;
    localparam int TOT_PRIOR0   = 11;
    localparam int TOT_ESCAPE   = 12;
    localparam int TOT_KEYS     = 13;

    // per-test counter index
    localparam int PT_ALLOC   = 0;
    localparam int PT_FREE    = 1;
    localparam int PT_BYTES   = 2;
    localparam int PT_REALLOC = 3;
    localparam int PT_PEAK    = 4;
    localparam int PT_ESCAPE  = 5;

    // histogram index
    localparam int H_GAP   = 0;
    localparam int H_BGAP  = 1;
    localparam int H_PRIOR = 2;
    localparam int H_SIZE  = 3;

    // read groups
    localparam logic [3:0] RG_HIST_LAST = 4'd3;
    localparam logic [3:0] RG_TOTALS    = 4'd4;
    localparam logic [3:0] RG_PT_FIRST  = 4'd5;
    localparam logic [3:0] RG_PT_LAST   = 4'd10;
    localparam logic [3:0] RG_REUSE     = 4'd11;

    // configuration register index
    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_BASE    = 2'd1;
    localparam logic [1:0] CFG_GRAN    = 2'd2;
    localparam logic [1:0] CFG_ENTRIES = 2'd3;

    typedef enum logic [2:0] {
        OP_ALLOC, OP_FREE, OP_REALLOC, OP_ESCAPE, OP_BEGIN, OP_END, OP_READ, OP_NOP
    } t_op;

    typedef enum logic [2:0] {
        ST_OK, ST_ARENA, ST_FULL, ST_TESTS, ST_BADRD
    } t_status;

    typedef enum logic [2:0] {
        FS_IDLE, FS_M0, FS_M1, FS_M2, FS_HASH, FS_PUSH
    } t_fstate;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISP, S_PROBE, S_CHECK, S_ERD, S_CALC, S_HRD, S_UPD, S_OUT
    } t_bstate;

    typedef struct packed {
        logic        mode;
        logic [63:0] base;
        logic [3:0]  gran;
        logic [12:0] entries;
    } t_cfg;

    typedef struct packed {
        t_op           op;
        t_status       status;
        logic          hashed;
        logic          nulladdr;
        logic [TB-1:0] slot;
        logic [63:0]   address;
        logic [31:0]   size;
        logic [3:0]    group;
        logic [11:0]   index;
    } t_item;

    typedef struct packed {
        t_status     status;
        logic [63:0] value;
        logic [7:0]  test;
    } t_result;

    function automatic logic [HB-1:0] floor_log2(input logic [63:0] x);
        logic [HB-1:0] k;
        k = '0;
        for (int i = 0; i < 64; i++) begin
            if (x[i]) k = HB'(i);
        end
        return k;
    endfunction

endpackage
`default_nettype wire

>>> sv/arm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module arm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> sv/arm_front.sv
// front end: accepts event words, hashes or maps the address, classifies
`default_nettype none
module arm_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire arm_pkg::t_cfg i_cfg,
    input  wire logic          i_hold,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_func,
    input  wire logic [63:0]   i_address,
    input  wire logic [31:0]   i_size,
    input  wire logic [3:0]    i_group,
    input  wire logic [11:0]   i_index,
    input  wire logic          i_full,
    output logic               o_push,
    output arm_pkg::t_item     o_item
);
    import arm_pkg::*;

    t_fstate r_state, n_state;
    logic [2:0]    r_func;
    logic [63:0]   r_addr;
    logic [31:0]   r_size;
    logic [3:0]    r_group;
    logic [11:0]   r_index;
    logic [63:0]   r_p0, r_p1, r_p2, r_diff, r_didx;
    logic          r_under, r_dbad;
    logic [TB-1:0] r_h;
    logic [31:0]   mul_a, mul_b;
    logic [63:0]   prod, hsum, lim;
    logic          accept, read_ok;
    t_op           op;

    assign accept = o_ready && i_valid;
    assign prod   = mul_a * mul_b;
    assign hsum   = r_p0 + {r_p1[31:0] + r_p2[31:0], 32'b0};
    assign lim    = (64'(i_cfg.entries) < 64'(SLOTS)) ? 64'(i_cfg.entries) : 64'(SLOTS);

    always_comb begin
        if (r_group <= RG_HIST_LAST)     read_ok = (32'(r_index) < 32'(HIST));
        else if (r_group == RG_TOTALS)   read_ok = (32'(r_index) < 32'(NTOT));
        else if (r_group <= RG_PT_LAST)  read_ok = (32'(r_index) < 32'(MAX_TESTS));
        else if (r_group == RG_REUSE)    read_ok = (32'(r_index) < 32'(SLOTS));
        else                             read_ok = 1'b0;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FS_IDLE: if (accept) begin
                n_state = (t_op'(i_func) == OP_ALLOC || t_op'(i_func) == OP_FREE)
                          ? FS_M0 : FS_PUSH;
            end
            FS_M0:   n_state = FS_M1;
            FS_M1:   n_state = FS_M2;
            FS_M2:   n_state = FS_HASH;
            FS_HASH: n_state = FS_PUSH;
            FS_PUSH: if (!i_full) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_push  = 1'b0;
        mul_a   = r_addr[31:0];
        mul_b   = HASH_MUL[31:0];
        case (r_state)
            FS_IDLE: o_ready = !i_hold;
            FS_M1:   mul_a = r_addr[63:32];
            FS_M2:   mul_b = HASH_MUL[63:32];
            FS_PUSH: o_push = !i_full;
            default: ;
        endcase
    end

    always_comb begin
        op = t_op'(r_func);
        if (op == OP_FREE && r_addr == '0) op = OP_NOP;
        o_item.op       = op;
        o_item.status   = ST_OK;
        if ((op == OP_ALLOC || op == OP_FREE) && r_addr != '0 && i_cfg.mode && r_dbad)
            o_item.status = ST_ARENA;
        else if (op == OP_READ && !read_ok)
            o_item.status = ST_BADRD;
        o_item.hashed   = !i_cfg.mode;
        o_item.nulladdr = (r_addr == '0);
        o_item.slot     = i_cfg.mode ? r_didx[TB-1:0] : r_h;
        o_item.address  = r_addr;
        o_item.size     = r_size;
        o_item.group    = r_group;
        o_item.index    = r_index;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
            case (r_state)
                FS_IDLE: if (accept) begin
                    r_func  <= i_func;
                    r_addr  <= i_address;
                    r_size  <= i_size;
                    r_group <= i_group;
                    r_index <= i_index;
                end
                FS_M0: begin
                    r_p0    <= prod;
                    r_diff  <= r_addr - i_cfg.base;
                    r_under <= r_addr < i_cfg.base;
                end
                FS_M1: begin
                    r_p1   <= prod;
                    r_didx <= r_diff >> i_cfg.gran;
                end
                FS_M2: begin
                    r_p2   <= prod;
                    r_dbad <= r_under || (r_didx >= lim);
                end
                FS_HASH: r_h <= hsum[63 -: TB];
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/arm_queue.sv
// short queue of classified events between front and back
`default_nettype none
module arm_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire arm_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output arm_pkg::t_item      o_item
);
    import arm_pkg::*;

    localparam int PW = $clog2(QDEPTH);

    t_item         r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_item;
                r_wp        <= (r_wp == PW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) r_rp <= (r_rp == PW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> sv/arm_back.sv
// back end: probes the table, updates entries, histograms and counters
`default_nettype none
`include "allocation_reuse_monitor_defines.svh"
module arm_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_empty,
    input  wire arm_pkg::t_item i_item,
    output logic                o_pop,
    output logic                o_busy,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output arm_pkg::t_result    o_res
);
    import arm_pkg::*;

    t_bstate r_state, n_state;
    t_item   r_item;
    logic [TB-1:0]       r_h, r_slot;
    logic [CLR_BITS-1:0] r_clr;
    logic [63:0]         r_tot [NTOT];
    logic [MT_BITS-1:0]  r_cur, r_seen;
    t_status             r_st;
    logic [63:0]         r_val;
    logic [HB-1:0]       r_bin [NHIST];
    logic                r_hdo [NHIST];
    logic                r_ovalid;
    t_result             r_ores;

    // ram ports
    logic          key_we;
    logic [TB-1:0] key_waddr, key_raddr, ent_waddr, ent_raddr;
    logic [63:0]   key_wdata, key_rd;
    logic          stamp_we, fbytes_we, reuse_we, size_we, fv_we;
    logic [EW-1:0] stamp_wd, fbytes_wd, reuse_wd, size_wd;
    logic [EW-1:0] stamp_rd, fbytes_rd, reuse_rd, size_rd;
    logic          fv_wd, fv_rd;
    logic          hist_we [NHIST];
    logic [HB-1:0] hist_waddr [NHIST], hist_raddr [NHIST];
    logic [63:0]   hist_wd [NHIST], hist_rd [NHIST];
    logic          pt_we [NPT];
    logic [MT_BITS-1:0] pt_waddr, pt_raddr;
    logic [63:0]   pt_wd [NPT], pt_rd [NPT];

    logic          clearing, out_load, key_hit, key_empty, keys_full, is_alloc, is_read;
    logic          tests_full;
    logic [EW-1:0] rc_new, gap_alloc, gap_bytes;
    logic [63:0]   live_new;

    assign clearing  = (r_state == S_CLEAR);
    assign o_busy    = clearing;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign out_load  = !r_ovalid || i_res_ready;
    assign key_hit   = (key_rd == r_item.address);
    assign key_empty = (key_rd == '0);
    assign keys_full = (r_tot[TOT_KEYS] >= 64'(SLOTS / 2));
    assign is_alloc  = (r_item.op == OP_ALLOC);
    assign is_read   = (r_item.op == OP_READ);
    assign tests_full = ({1'b0, r_seen} + 1'b1 >= (MT_BITS+1)'(MAX_TESTS));
    assign rc_new    = (reuse_rd == '1) ? reuse_rd : reuse_rd + 1'b1;
    assign live_new  = r_tot[TOT_LIVE] + 64'd1;
    // gaps wrap at the entry width, like the stamps
    assign gap_alloc = r_tot[TOT_ALLOC][EW-1:0] + 1'b1 - stamp_rd;
    assign gap_bytes = r_tot[TOT_FBYTES][EW-1:0] - fbytes_rd;
    assign o_res_valid = r_ovalid;
    assign o_res       = r_ores;

    arm_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (.i_clk, .i_we(key_we),
        .i_waddr(key_waddr), .i_wdata(key_wdata), .i_raddr(key_raddr), .o_rdata(key_rd));
    arm_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_stamp (.i_clk, .i_we(stamp_we),
        .i_waddr(ent_waddr), .i_wdata(stamp_wd), .i_raddr(ent_raddr), .o_rdata(stamp_rd));
    arm_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_fbytes (.i_clk, .i_we(fbytes_we),
        .i_waddr(ent_waddr), .i_wdata(fbytes_wd), .i_raddr(ent_raddr), .o_rdata(fbytes_rd));
    arm_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_reuse (.i_clk, .i_we(reuse_we),
        .i_waddr(ent_waddr), .i_wdata(reuse_wd), .i_raddr(ent_raddr), .o_rdata(reuse_rd));
    arm_ram #(.WIDTH(EW), .DEPTH(SLOTS)) u_size (.i_clk, .i_we(size_we),
        .i_waddr(ent_waddr), .i_wdata(size_wd), .i_raddr(ent_raddr), .o_rdata(size_rd));
    arm_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_fv (.i_clk, .i_we(fv_we),
        .i_waddr(ent_waddr), .i_wdata(fv_wd), .i_raddr(ent_raddr), .o_rdata(fv_rd));

    for (genvar k = 0; k < NHIST; k++) begin : g_hist
        arm_ram #(.WIDTH(64), .DEPTH(HIST)) u_hist (.i_clk, .i_we(hist_we[k]),
            .i_waddr(hist_waddr[k]), .i_wdata(hist_wd[k]), .i_raddr(hist_raddr[k]),
            .o_rdata(hist_rd[k]));
    end

    for (genvar k = 0; k < NPT; k++) begin : g_pt
        arm_ram #(.WIDTH(64), .DEPTH(MAX_TESTS)) u_pt (.i_clk, .i_we(pt_we[k]),
            .i_waddr(pt_waddr), .i_wdata(pt_wd[k]), .i_raddr(pt_raddr), .o_rdata(pt_rd[k]));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: if (r_clr == '1) n_state = S_IDLE;
            S_IDLE:  if (!i_empty) n_state = S_DISP;
            S_DISP: begin
                if (r_item.status != ST_OK) n_state = S_OUT;
                else begin
                    case (r_item.op)
                        OP_ALLOC, OP_FREE: begin
                            if (r_item.nulladdr || !r_item.hashed) n_state = S_ERD;
                            else n_state = S_PROBE;
                        end
                        OP_REALLOC, OP_ESCAPE, OP_READ: n_state = S_ERD;
                        default: n_state = S_OUT;
                    endcase
                end
            end
            S_PROBE: n_state = S_CHECK;
            S_CHECK: begin
                if (key_hit) n_state = S_ERD;
                else if (key_empty) n_state = keys_full ? S_OUT : S_ERD;
                else n_state = S_PROBE;
            end
            S_ERD:  n_state = S_CALC;
            S_CALC: n_state = is_read ? S_OUT : S_HRD;
            S_HRD:  n_state = S_UPD;
            S_UPD:  n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ram control
    always_comb begin
        key_we    = 1'b0;
        key_waddr = r_h;
        key_wdata = r_item.address;
        key_raddr = r_h;
        ent_raddr = is_read ? TB'(r_item.index) : r_slot;
        ent_waddr = r_slot;
        stamp_we  = 1'b0;
        fbytes_we = 1'b0;
        reuse_we  = 1'b0;
        size_we   = 1'b0;
        fv_we     = 1'b0;
        stamp_wd  = r_tot[TOT_ALLOC][EW-1:0];
        fbytes_wd = r_tot[TOT_FBYTES][EW-1:0];
        reuse_wd  = rc_new;
        size_wd   = r_item.size[EW-1:0];
        fv_wd     = (r_item.op == OP_FREE);
        pt_raddr  = is_read ? MT_BITS'(r_item.index) : r_cur;
        pt_waddr  = r_cur;
        for (int k = 0; k < NHIST; k++) begin
            hist_we[k]    = 1'b0;
            hist_waddr[k] = r_bin[k];
            hist_raddr[k] = (r_state == S_HRD) ? r_bin[k] : HB'(r_item.index);
            hist_wd[k]    = hist_rd[k] + 64'd1;
        end
        for (int k = 0; k < NPT; k++) begin
            pt_we[k] = 1'b0;
            pt_wd[k] = pt_rd[k] + 64'd1;
        end
        pt_wd[PT_BYTES] = pt_rd[PT_BYTES] + 64'(r_item.size);
        pt_wd[PT_PEAK]  = (live_new > pt_rd[PT_PEAK]) ? live_new : pt_rd[PT_PEAK];
        case (r_state)
            S_CLEAR: begin
                key_we    = 1'b1;
                key_waddr = TB'(r_clr);
                key_wdata = '0;
                ent_waddr = TB'(r_clr);
                stamp_we  = 1'b1;
                fbytes_we = 1'b1;
                reuse_we  = 1'b1;
                size_we   = 1'b1;
                fv_we     = 1'b1;
                stamp_wd  = '0;
                fbytes_wd = '0;
                reuse_wd  = '0;
                size_wd   = '0;
                fv_wd     = 1'b0;
                pt_waddr  = MT_BITS'(r_clr);
                for (int k = 0; k < NHIST; k++) begin
                    hist_we[k]    = 1'b1;
                    hist_waddr[k] = HB'(r_clr);
                    hist_wd[k]    = '0;
                end
                for (int k = 0; k < NPT; k++) begin
                    pt_we[k] = 1'b1;
                    pt_wd[k] = '0;
                end
            end
            S_CHECK: key_we = !key_hit && key_empty && !keys_full;
            S_UPD: begin
                for (int k = 0; k < NHIST; k++) hist_we[k] = r_hdo[k];
                case (r_item.op)
                    OP_ALLOC: begin
                        reuse_we = !r_item.nulladdr;
                        size_we  = !r_item.nulladdr;
                        fv_we    = !r_item.nulladdr;
                        pt_we[PT_ALLOC] = 1'b1;
                        pt_we[PT_BYTES] = 1'b1;
                        pt_we[PT_PEAK]  = 1'b1;
                    end
                    OP_FREE: begin
                        stamp_we  = 1'b1;
                        fbytes_we = 1'b1;
                        fv_we     = 1'b1;
                        pt_we[PT_FREE] = 1'b1;
                    end
                    OP_REALLOC: pt_we[PT_REALLOC] = 1'b1;
                    OP_ESCAPE:  pt_we[PT_ESCAPE]  = 1'b1;
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cur    <= '0;
            r_seen   <= '0;
            r_ovalid <= 1'b0;
            for (int k = 0; k < NTOT; k++) r_tot[k] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT && out_load) r_ovalid <= 1'b1;
            else if (i_res_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_CLEAR: r_clr <= r_clr + 1'b1;
                S_IDLE:  if (!i_empty) r_item <= i_item;
                S_DISP: begin
                    r_val  <= '0;
                    r_h    <= r_item.slot;
                    r_slot <= r_item.slot;
                    if (r_item.status == ST_OK && r_item.op == OP_BEGIN && tests_full)
                        r_st <= ST_TESTS;
                    else
                        r_st <= r_item.status;
                    if (r_item.status == ST_OK) begin
                        if (r_item.op == OP_BEGIN) begin
                            if (!tests_full) begin
                                r_seen <= r_seen + 1'b1;
                                r_cur  <= r_seen + 1'b1;
                            end
                        end else if (r_item.op == OP_END) begin
                            r_cur <= '0;
                        end
                    end
                end
                S_CHECK: begin
                    if (key_hit) r_slot <= r_h;
                    else if (key_empty) begin
                        if (keys_full) r_st <= ST_FULL;
                        else begin
                            r_tot[TOT_KEYS] <= r_tot[TOT_KEYS] + 64'd1;
                            r_slot          <= r_h;
                        end
                    end else r_h <= r_h + 1'b1;
                end
                S_CALC: begin
                    r_bin[H_GAP]   <= floor_log2(64'(gap_alloc));
                    r_bin[H_BGAP]  <= floor_log2(64'(gap_bytes));
                    r_bin[H_PRIOR] <= floor_log2(64'(reuse_rd));
                    r_bin[H_SIZE]  <= floor_log2(64'(r_item.size));
                    r_hdo[H_GAP]   <= is_alloc && !r_item.nulladdr && fv_rd;
                    r_hdo[H_BGAP]  <= is_alloc && !r_item.nulladdr && fv_rd;
                    r_hdo[H_PRIOR] <= is_alloc && !r_item.nulladdr && (reuse_rd != '0);
                    r_hdo[H_SIZE]  <= is_alloc && (r_item.size != '0);
                    if (is_read) begin
                        if (r_item.group <= RG_HIST_LAST)
                            r_val <= hist_rd[r_item.group[1:0]];
                        else if (r_item.group == RG_TOTALS)
                            r_val <= r_tot[r_item.index[3:0]];
                        else if (r_item.group <= RG_PT_LAST)
                            r_val <= pt_rd[3'(r_item.group - RG_PT_FIRST)];
                        else
                            r_val <= 64'(reuse_rd);
                    end
                end
                S_UPD: begin
                    case (r_item.op)
                        OP_ALLOC: begin
                            r_tot[TOT_ALLOC] <= r_tot[TOT_ALLOC] + 64'd1;
                            r_tot[TOT_BYTES] <= r_tot[TOT_BYTES] + 64'(r_item.size);
                            r_tot[TOT_LIVE]  <= live_new;
                            if (live_new > r_tot[TOT_PEAK]) r_tot[TOT_PEAK] <= live_new;
                            if (!r_item.nulladdr) begin
                                if (reuse_rd == '0) begin
                                    r_tot[TOT_PRIOR0]   <= r_tot[TOT_PRIOR0] + 64'd1;
                                    r_tot[TOT_DISTINCT] <= r_tot[TOT_DISTINCT] + 64'd1;
                                end
                                if (reuse_rd >= EW'(GEN_LIMIT))
                                    r_tot[TOT_BEYOND] <= r_tot[TOT_BEYOND] + 64'd1;
                                // count of 16-byte words, rounded up
                                r_tot[TOT_POISON] <= r_tot[TOT_POISON]
                                    + 64'((33'(r_item.size) + 33'd15) >> 4);
                                if (64'(rc_new) > r_tot[TOT_MAXREUSE])
                                    r_tot[TOT_MAXREUSE] <= 64'(rc_new);
                            end
                        end
                        OP_FREE: begin
                            r_tot[TOT_FREE] <= r_tot[TOT_FREE] + 64'd1;
                            if (r_tot[TOT_LIVE] != '0)
                                r_tot[TOT_LIVE] <= r_tot[TOT_LIVE] - 64'd1;
                            r_tot[TOT_FBYTES] <= r_tot[TOT_FBYTES] + 64'(size_rd);
                        end
                        OP_REALLOC: r_tot[TOT_REALLOC] <= r_tot[TOT_REALLOC] + 64'd1;
                        OP_ESCAPE:  r_tot[TOT_ESCAPE]  <= r_tot[TOT_ESCAPE] + 64'd1;
                        default: ;
                    endcase
                end
                S_OUT: if (out_load) begin
                    r_ores.status <= r_st;
                    r_ores.value  <= r_val;
                    r_ores.test   <= 8'(r_cur);
                end
                default: ;
            endcase
        end
    end

    `ARM_ASSERT_ALWAYS(a_keys_bound, i_clk, i_rst_n, r_tot[TOT_KEYS] <= 64'(SLOTS / 2), "hashed keys above half the table")
    `ARM_ASSERT_ALWAYS(a_peak_live, i_clk, i_rst_n, r_tot[TOT_PEAK] >= r_tot[TOT_LIVE], "live count above peak")
    `ARM_ASSERT_IMPLY(a_test_slot, i_clk, i_rst_n, r_cur != '0, r_cur <= r_seen, "current test beyond tests seen")
    `ARM_ASSERT_NEXT(a_hit_goes_on, i_clk, i_rst_n, (r_state == S_CHECK) && key_hit, r_state == S_ERD, "key hit did not proceed to entry read")

endmodule
`default_nettype wire

>>> sv/allocation_reuse_monitor.sv
// allocation reuse monitor: top level with config registers and stream ports
// events pass the front end, a two-entry queue and the back end; each hash probe in
// hashed mode adds a probe and a check step, and the result may wait for the output
// the front accepts a new event only after its last one is pushed, and the back end
// takes the next queued event only after its result is handed to the output stage
// reset: synchronous active low, then a clearing pass over all memories
// with the input not ready; config writes are taken during that pass
`default_nettype none
module allocation_reuse_monitor (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [63:0]   i_cfg_wdata,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [111:0]  s_axis_tdata,  // address, size, read_group, read_index
    input  wire logic [2:0]    s_axis_tuser,  // func
    output logic               m_axis_tvalid,
    input  wire logic          m_axis_tready,
    output logic [79:0]        m_axis_tdata   // status, read_value, test_slot, zero fill
);
    import arm_pkg::*;

    t_cfg    r_cfg;
    t_item   f_item, q_item;
    t_result res;
    logic    f_push, q_full, q_empty, q_pop, busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= 1'b0;
            r_cfg.base    <= '0;
            r_cfg.gran    <= 4'd6;
            r_cfg.entries <= 13'd4096;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MODE:    r_cfg.mode    <= i_cfg_wdata[0];
                CFG_BASE:    r_cfg.base    <= i_cfg_wdata;
                CFG_GRAN:    r_cfg.gran    <= i_cfg_wdata[3:0];
                CFG_ENTRIES: r_cfg.entries <= i_cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    arm_front u_front (
        .i_clk, .i_rst_n,
        .i_cfg    (r_cfg),
        .i_hold   (busy),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_func   (s_axis_tuser),
        .i_address(s_axis_tdata[63:0]),
        .i_size   (s_axis_tdata[95:64]),
        .i_group  (s_axis_tdata[99:96]),
        .i_index  (s_axis_tdata[111:100]),
        .i_full   (q_full),
        .o_push   (f_push),
        .o_item   (f_item)
    );

    arm_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push (f_push),
        .i_item (f_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_item (q_item)
    );

    arm_back u_back (
        .i_clk, .i_rst_n,
        .i_empty    (q_empty),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .o_busy     (busy),
        .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .o_res      (res)
    );

    assign m_axis_tdata = {5'b0, res.test, res.value, res.status};
endmodule
`default_nettype wire
